/* rtl/dq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants, codes and controller/datapath interface types for the
// double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int WORD_W        = 32;
    localparam int FUNC_W        = 3;
    localparam int LEVEL_W       = 7;
    localparam int STATUS_W      = 2;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL_RESET = 7'd52;

    localparam logic [FUNC_W-1:0] FN_QUERY      = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PUSH_REAR  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_POP_REAR   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic latch_in;
        logic update;
        logic load_out;
    } dq_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dq_stat_t;

endpackage

`default_nettype wire

/* rtl/dq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer for one deque operation: latch, read old ends, update, read new
// ends, load result register.
// ----------------------------------------------------------------------------
module dq_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire dq_pkg::dq_stat_t stat,
    output dq_pkg::dq_cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD0  = 5'b00010,
        S_UPD  = 5'b00100,
        S_RD1  = 5'b01000,
        S_LOAD = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.latch_in = 1'b0;
        cmd.update   = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_RD0;
                end
            end
            S_RD0:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // one word in flight: no new word until the result is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("dq_ctrl: accepted while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch_in |-> ##2 cmd.update)
        else $error("dq_ctrl: update not two cycles after latch");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !stat.out_busy)
        else $error("dq_ctrl: result overwritten");

endmodule

`default_nettype wire

/* rtl/dq_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_datapath
// Ring store, front pointer, entry count and result register of the deque.
// ----------------------------------------------------------------------------
module dq_datapath
#(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire dq_pkg::dq_cmd_t                cmd,
    output dq_pkg::dq_stat_t                    stat,
    input  wire logic [dq_pkg::FUNC_W-1:0]      in_func,
    input  wire logic [dq_pkg::WORD_W-1:0]      in_value,
    input  wire logic [dq_pkg::LEVEL_W-1:0]     full_level,
    output logic [dq_pkg::WORD_W-1:0]           out_popped_value,
    output logic                                out_popped_valid,
    output logic [dq_pkg::WORD_W-1:0]           out_front_value,
    output logic [dq_pkg::WORD_W-1:0]           out_rear_value,
    output logic                                out_is_empty,
    output logic                                out_is_full,
    output logic [dq_pkg::STATUS_W-1:0]         out_status,
    output logic                                out_valid,
    input  wire logic                           out_ready
);

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > dq_pkg::LEVEL_W) ? CW : dq_pkg::LEVEL_W;

    logic [dq_pkg::WORD_W-1:0] mem [DEPTH];

    logic [IW-1:0]                  front_reg, front_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [dq_pkg::FUNC_W-1:0]      func_reg;
    logic [dq_pkg::WORD_W-1:0]      value_reg;
    logic [dq_pkg::WORD_W-1:0]      rd_front_reg, rd_rear_reg;
    logic [dq_pkg::WORD_W-1:0]      popped_reg, popped_next;
    logic                           pvalid_reg, pvalid_next;
    logic [dq_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic                           out_valid_reg;

    logic [dq_pkg::WORD_W-1:0]      out_popped_value_reg;
    logic                           out_popped_valid_reg;
    logic [dq_pkg::WORD_W-1:0]      out_front_value_reg;
    logic [dq_pkg::WORD_W-1:0]      out_rear_value_reg;
    logic                           out_is_empty_reg;
    logic                           out_is_full_reg;
    logic [dq_pkg::STATUS_W-1:0]    out_status_reg;

    logic                           we;
    logic [IW-1:0]                  waddr;
    logic [IW-1:0]                  rear_idx;
    logic [IW-1:0]                  front_dec;
    logic                           full_now;
    logic [CMPW-1:0]                count_ext, level_ext;

    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] idx,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(idx) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign rear_idx  = (count_reg == '0) ? front_reg : ring_add(front_reg, count_reg - 1'b1);
    assign front_dec = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - 1'b1;
    assign count_ext = CMPW'(count_reg);
    assign level_ext = CMPW'(full_level);
    assign full_now  = (count_ext >= level_ext) || (count_reg >= CW'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= value_reg;
        end
        rd_front_reg <= mem[front_reg];
        rd_rear_reg  <= mem[rear_idx];
    end

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        popped_next = '0;
        pvalid_next = 1'b0;
        status_next = dq_pkg::ST_OK;
        we          = 1'b0;
        waddr       = front_reg;
        case (func_reg)
            dq_pkg::FN_PUSH_FRONT:
            begin
                if (full_now)
                begin
                    status_next = dq_pkg::ST_PUSH_FULL;
                end
                else
                begin
                    front_next = front_dec;
                    we         = 1'b1;
                    waddr      = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            dq_pkg::FN_PUSH_REAR:
            begin
                if (full_now)
                begin
                    status_next = dq_pkg::ST_PUSH_FULL;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = ring_add(front_reg, count_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            dq_pkg::FN_POP_FRONT:
            begin
                if (count_reg == '0)
                begin
                    status_next = dq_pkg::ST_POP_EMPTY;
                end
                else
                begin
                    popped_next = rd_front_reg;
                    pvalid_next = 1'b1;
                    front_next  = ring_add(front_reg, CW'(1));
                    count_next  = count_reg - 1'b1;
                end
            end
            dq_pkg::FN_POP_REAR:
            begin
                if (count_reg == '0)
                begin
                    status_next = dq_pkg::ST_POP_EMPTY;
                end
                else
                begin
                    popped_next = rd_rear_reg;
                    pvalid_next = 1'b1;
                    count_next  = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = dq_pkg::ST_OK;
            end
        endcase
        if (!cmd.update)
        begin
            we         = 1'b0;
            front_next = front_reg;
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            func_reg  <= in_func;
            value_reg <= in_value;
        end
        if (cmd.update)
        begin
            popped_reg <= popped_next;
            pvalid_reg <= pvalid_next;
            status_reg <= status_next;
        end
        if (cmd.load_out)
        begin
            out_popped_value_reg <= popped_reg;
            out_popped_valid_reg <= pvalid_reg;
            out_front_value_reg  <= (count_reg == '0) ? '0 : rd_front_reg;
            out_rear_value_reg   <= (count_reg == '0) ? '0 : rd_rear_reg;
            out_is_empty_reg     <= (count_reg == '0);
            out_is_full_reg      <= (count_ext == level_ext);
            out_status_reg       <= status_reg;
        end
    end

    assign out_popped_value = out_popped_value_reg;
    assign out_popped_valid = out_popped_valid_reg;
    assign out_front_value  = out_front_value_reg;
    assign out_rear_value   = out_rear_value_reg;
    assign out_is_empty     = out_is_empty_reg;
    assign out_is_full      = out_is_full_reg;
    assign out_status       = out_status_reg;

    assign out_valid     = out_valid_reg;
    assign stat.out_busy = out_valid_reg && !out_ready;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("dq_datapath: count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && pvalid_next) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("dq_datapath: pop did not decrement count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && (status_next == dq_pkg::ST_PUSH_FULL)) |=>
            ($stable(count_reg) && $stable(front_reg)))
        else $error("dq_datapath: refused push changed state");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("dq_datapath: loaded result not presented");

endmodule

`default_nettype wire

/* rtl/double_ended_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of signed 32-bit words held in a ring store.
// ----------------------------------------------------------------------------
// Each input word carries an operation in s_tuser (query, push front, push
// rear, pop front, pop rear) and a push value in s_tdata; each produces one
// output word with the popped value, the new front and rear values, empty
// and full flags and a status. The result register is loaded once the
// store has been read for the old ends, updated, and read again for the
// new ends, and once the output register is free; no new word is taken
// until then. A finished result waits in the output register while the
// next word is accepted. full_level
// (APB byte address 0, reset 52) sets the count at which pushes are refused.
// The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module double_ended_queue
#(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [2:0]  s_tuser,   // [2:0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // [31:0] popped_value, [63:32] front_value,
                                        // [95:64] rear_value
    output logic [4:0]       m_tuser,   // [0] popped_valid, [1] is_empty,
                                        // [2] is_full, [4:3] status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [dq_pkg::LEVEL_W-1:0] full_level_reg;
    logic                       reg_sel;
    dq_pkg::dq_cmd_t            cmd;
    dq_pkg::dq_stat_t           stat;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == 1'b0);
    assign prdata  = reg_sel ? 32'(full_level_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_level_reg <= dq_pkg::FULL_LEVEL_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            full_level_reg <= pwdata[dq_pkg::LEVEL_W-1:0];
        end
    end

    dq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .in_func          (s_tuser),
        .in_value         (s_tdata),
        .full_level       (full_level_reg),
        .out_popped_value (m_tdata[31:0]),
        .out_popped_valid (m_tuser[0]),
        .out_front_value  (m_tdata[63:32]),
        .out_rear_value   (m_tdata[95:64]),
        .out_is_empty     (m_tuser[1]),
        .out_is_full      (m_tuser[2]),
        .out_status       (m_tuser[4:3]),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready)
    );

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-ended queue.
// ----------------------------------------------------------------------------
// A directed table covers the empty, single-entry and refused cases and the
// odd full levels. Random phases then fill and drain the ring across several
// full levels. Every result word is checked field by field: typed rows
// against their table word, the rest against a shadow deque updated on
// each accepted input word. Both stream sides idle at random, and the
// output side is held off once long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH       = dq_pkg::DEPTH_DEFAULT;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int DIR_N       = 26;
    localparam int PHASE_N     = 6;
    localparam int PHASE_WORDS = 180;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE      = 12;

    localparam logic [2:0] LEVEL_ADDR = 3'd0;
    localparam logic [2:0] STRAY_ADDR = 3'd4;

    localparam logic [dq_pkg::FUNC_W-1:0] FN_UNUSED_5 = 3'd5;
    localparam logic [dq_pkg::FUNC_W-1:0] FN_UNUSED_6 = 3'd6;
    localparam logic [dq_pkg::FUNC_W-1:0] FN_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [dq_pkg::WORD_W-1:0]   popped;
        logic                        pop_ok;
        logic [dq_pkg::WORD_W-1:0]   front;
        logic [dq_pkg::WORD_W-1:0]   rear;
        logic                        empty;
        logic                        full;
        logic [dq_pkg::STATUS_W-1:0] status;
    } deque_result_t;

    typedef enum logic [1:0] {ROW_WORD, ROW_LEVEL, ROW_STRAY} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic [dq_pkg::FUNC_W-1:0] func;
        logic [dq_pkg::WORD_W-1:0] value;
        bit                        typed;
        deque_result_t             want;
    } stim_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow deque
    logic [dq_pkg::WORD_W-1:0]  shadow_mem [DEPTH];
    logic [PTR_W-1:0]           shadow_head = '0;
    logic [dq_pkg::LEVEL_W-1:0] shadow_cnt  = '0;
    logic [dq_pkg::LEVEL_W-1:0] shadow_level = dq_pkg::FULL_LEVEL_RESET;

    deque_result_t pending_results [$];

    int  errors      = 0;
    int  words_in    = 0;
    int  results_out = 0;
    int  send_idle_pct = 0;
    int  stall_pct     = 0;
    int  n_refused   = 0;
    int  n_empty_pop = 0;
    int  n_full_seen = 0;
    int  max_fill    = 0;
    logic hold_rx    = 1'b0;

    stim_row_t dir_rows [DIR_N] = '{
        '{ROW_WORD,  dq_pkg::FN_QUERY,      32'h0,        1'b1,
          '{32'h0, 1'b0, 32'h0, 32'h0, 1'b1, 1'b0, dq_pkg::ST_OK}},
        '{ROW_WORD,  dq_pkg::FN_POP_FRONT,  32'h12345678, 1'b1,
          '{32'h0, 1'b0, 32'h0, 32'h0, 1'b1, 1'b0, dq_pkg::ST_POP_EMPTY}},
        '{ROW_WORD,  dq_pkg::FN_POP_REAR,   32'hFFFFFFFF, 1'b1,
          '{32'h0, 1'b0, 32'h0, 32'h0, 1'b1, 1'b0, dq_pkg::ST_POP_EMPTY}},
        '{ROW_WORD,  dq_pkg::FN_PUSH_FRONT, 32'h7FFFFFFF, 1'b1,
          '{32'h0, 1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 1'b0, dq_pkg::ST_OK}},
        '{ROW_WORD,  dq_pkg::FN_POP_REAR,   32'h0,        1'b1,
          '{32'h7FFFFFFF, 1'b1, 32'h0, 32'h0, 1'b1, 1'b0, dq_pkg::ST_OK}},
        '{ROW_WORD,  dq_pkg::FN_PUSH_REAR,  32'h80000000, 1'b1,
          '{32'h0, 1'b0, 32'h80000000, 32'h80000000, 1'b0, 1'b0, dq_pkg::ST_OK}},
        '{ROW_WORD,  dq_pkg::FN_PUSH_FRONT, 32'hFFFFFFFF, 1'b1,
          '{32'h0, 1'b0, 32'hFFFFFFFF, 32'h80000000, 1'b0, 1'b0, dq_pkg::ST_OK}},
        '{ROW_WORD,  dq_pkg::FN_PUSH_REAR,  32'h0,        1'b1,
          '{32'h0, 1'b0, 32'hFFFFFFFF, 32'h0, 1'b0, 1'b0, dq_pkg::ST_OK}},
        '{ROW_WORD,  FN_UNUSED_5,           32'hAAAAAAAA, 1'b0, '0},
        '{ROW_WORD,  FN_UNUSED_6,           32'h55555555, 1'b0, '0},
        '{ROW_WORD,  FN_UNUSED_7,           32'h0,        1'b0, '0},
        '{ROW_WORD,  dq_pkg::FN_PUSH_FRONT, 32'h00000001, 1'b0, '0},
        '{ROW_WORD,  dq_pkg::FN_POP_FRONT,  32'h0,        1'b0, '0},
        '{ROW_WORD,  dq_pkg::FN_POP_REAR,   32'h0,        1'b0, '0},
        '{ROW_WORD,  dq_pkg::FN_POP_FRONT,  32'h0,        1'b0, '0},
        '{ROW_WORD,  dq_pkg::FN_POP_FRONT,  32'h0,        1'b0, '0},
        '{ROW_LEVEL, dq_pkg::FN_QUERY,      32'd0,        1'b0, '0},
        '{ROW_WORD,  dq_pkg::FN_QUERY,      32'h0,        1'b1,
          '{32'h0, 1'b0, 32'h0, 32'h0, 1'b1, 1'b1, dq_pkg::ST_OK}},
        '{ROW_WORD,  dq_pkg::FN_PUSH_REAR,  32'h00000001, 1'b1,
          '{32'h0, 1'b0, 32'h0, 32'h0, 1'b1, 1'b1, dq_pkg::ST_PUSH_FULL}},
        '{ROW_LEVEL, dq_pkg::FN_QUERY,      32'd1,        1'b0, '0},
        '{ROW_WORD,  dq_pkg::FN_PUSH_FRONT, 32'h00000001, 1'b1,
          '{32'h0, 1'b0, 32'h1, 32'h1, 1'b0, 1'b1, dq_pkg::ST_OK}},
        '{ROW_WORD,  dq_pkg::FN_PUSH_REAR,  32'hFFFFFFFE, 1'b1,
          '{32'h0, 1'b0, 32'h1, 32'h1, 1'b0, 1'b1, dq_pkg::ST_PUSH_FULL}},
        '{ROW_STRAY, dq_pkg::FN_QUERY,      32'd0,        1'b0, '0},
        '{ROW_WORD,  dq_pkg::FN_PUSH_FRONT, 32'h00000005, 1'b1,
          '{32'h0, 1'b0, 32'h1, 32'h1, 1'b0, 1'b1, dq_pkg::ST_PUSH_FULL}},
        '{ROW_WORD,  dq_pkg::FN_POP_FRONT,  32'h0,        1'b1,
          '{32'h1, 1'b1, 32'h0, 32'h0, 1'b1, 1'b0, dq_pkg::ST_OK}},
        '{ROW_LEVEL, dq_pkg::FN_QUERY,      32'd52,       1'b0, '0}
    };

    double_ended_queue #(.DEPTH(DEPTH)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    // Applies one operation to the shadow deque and returns the result word.
    task automatic deque_apply(input logic [dq_pkg::FUNC_W-1:0] func,
                               input logic [dq_pkg::WORD_W-1:0] value,
                               output deque_result_t res);
        logic             full_now;
        logic [PTR_W-1:0] idx;
        begin
            res      = '0;
            res.status = dq_pkg::ST_OK;
            full_now = (shadow_cnt >= shadow_level) || (int'(shadow_cnt) >= DEPTH);
            case (func)
                dq_pkg::FN_PUSH_FRONT, dq_pkg::FN_PUSH_REAR:
                begin
                    if (full_now)
                    begin
                        res.status = dq_pkg::ST_PUSH_FULL;
                        n_refused++;
                    end
                    else if (func == dq_pkg::FN_PUSH_FRONT)
                    begin
                        shadow_head = shadow_head - 1'b1;
                        shadow_mem[shadow_head] = value;
                        shadow_cnt++;
                    end
                    else
                    begin
                        idx = shadow_head + shadow_cnt[PTR_W-1:0];
                        shadow_mem[idx] = value;
                        shadow_cnt++;
                    end
                end
                dq_pkg::FN_POP_FRONT, dq_pkg::FN_POP_REAR:
                begin
                    if (shadow_cnt == '0)
                    begin
                        res.status = dq_pkg::ST_POP_EMPTY;
                        n_empty_pop++;
                    end
                    else
                    begin
                        if (func == dq_pkg::FN_POP_FRONT)
                        begin
                            res.popped  = shadow_mem[shadow_head];
                            shadow_head = shadow_head + 1'b1;
                        end
                        else
                        begin
                            idx = shadow_head + shadow_cnt[PTR_W-1:0] - 1'b1;
                            res.popped = shadow_mem[idx];
                        end
                        res.pop_ok = 1'b1;
                        shadow_cnt--;
                    end
                end
                default: ;
            endcase
            idx       = shadow_head + shadow_cnt[PTR_W-1:0] - 1'b1;
            res.front = (shadow_cnt != '0) ? shadow_mem[shadow_head] : '0;
            res.rear  = (shadow_cnt != '0) ? shadow_mem[idx] : '0;
            res.empty = (shadow_cnt == '0);
            res.full  = (shadow_cnt == shadow_level);
            if (res.full)
                n_full_seen++;
            if (int'(shadow_cnt) > max_fill)
                max_fill = int'(shadow_cnt);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("[%0t] mismatch on result %0d, %s: got %h, want %h",
                     $realtime, results_out, what, got, want);
            errors++;
        end
    endtask

    task automatic send_word(input logic [dq_pkg::FUNC_W-1:0] func,
                             input logic [dq_pkg::WORD_W-1:0] value,
                             input bit typed, input deque_result_t want);
        deque_result_t res;
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= func;
            s_tdata  <= value;
            do
                @(posedge clk);
            while (!s_tready);
            deque_apply(func, value, res);
            pending_results.push_back(typed ? want : res);
            words_in++;
        end
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= addr;
            pwdata  <= data;
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic check_level_readback;
        logic [31:0] rd;
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= LEVEL_ADDR;
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            rd = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
            if (rd[dq_pkg::LEVEL_W-1:0] !== shadow_level)
                report_mismatch("full_level readback", rd, 32'(shadow_level));
        end
    endtask

    // Register writes only once the queue has gone quiet.
    task automatic write_config(input logic [2:0] addr, input logic [31:0] data);
        begin
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
            apb_write(addr, data);
            if (addr == LEVEL_ADDR)
                shadow_level = data[dq_pkg::LEVEL_W-1:0];
            check_level_readback();
        end
    endtask

    function automatic logic [dq_pkg::WORD_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h80000000;
            1:       return 32'h7FFFFFFF;
            2:       return 32'h00000000;
            3:       return 32'hFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [dq_pkg::FUNC_W-1:0] pick_func(input bit filling);
        int r;
        begin
            r = $urandom_range(99);
            if (r < 88)
            begin
                if ((r < 80) == filling)
                    return $urandom_range(1) ? dq_pkg::FN_PUSH_FRONT : dq_pkg::FN_PUSH_REAR;
                return $urandom_range(1) ? dq_pkg::FN_POP_FRONT : dq_pkg::FN_POP_REAR;
            end
            if (r < 96)
                return dq_pkg::FN_QUERY;
            case ($urandom_range(2))
                0:       return FN_UNUSED_5;
                1:       return FN_UNUSED_6;
                default: return FN_UNUSED_7;
            endcase
        end
    endfunction

    // output side
    always @(posedge clk)
    begin
        if (!rst_n || hold_rx)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // long hold-off on the output side so the block backs up
    initial
    begin
        wait (words_in >= HOLD_AT);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result word with nothing expected", 32'(m_tuser), 32'h0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.popped)
                    report_mismatch("popped_value", m_tdata[31:0], want.popped);
                if (m_tuser[0] !== want.pop_ok)
                    report_mismatch("popped_valid", 32'(m_tuser[0]), 32'(want.pop_ok));
                if (m_tdata[63:32] !== want.front)
                    report_mismatch("front_value", m_tdata[63:32], want.front);
                if (m_tdata[95:64] !== want.rear)
                    report_mismatch("rear_value", m_tdata[95:64], want.rear);
                if (m_tuser[1] !== want.empty)
                    report_mismatch("is_empty", 32'(m_tuser[1]), 32'(want.empty));
                if (m_tuser[2] !== want.full)
                    report_mismatch("is_full", 32'(m_tuser[2]), 32'(want.full));
                if (m_tuser[4:3] !== want.status)
                    report_mismatch("status", 32'(m_tuser[4:3]), 32'(want.status));
            end
            results_out++;
        end
    end

    initial
    begin
        int            phase_level [PHASE_N];
        int            mode;
        deque_result_t none;

        none = '0;
        phase_level = '{52, 64, 127, 1, 0, 0};
        phase_level[4] = $urandom_range(2, 63);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (dir_rows[i])
        begin
            case (dir_rows[i].kind)
                ROW_LEVEL: write_config(LEVEL_ADDR, dir_rows[i].value);
                ROW_STRAY: write_config(STRAY_ADDR, dir_rows[i].value);
                default:   send_word(dir_rows[i].func, dir_rows[i].value,
                                     dir_rows[i].typed, dir_rows[i].want);
            endcase
        end

        for (int p = 0; p < PHASE_N; p++)
        begin
            write_config(LEVEL_ADDR, 32'(phase_level[p]));
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                mode = (k / 45) % 4;
                send_idle_pct = (mode == 1) ? 77 : (mode == 3) ? 19 : 0;
                stall_pct     = (mode == 2) ? 77 : (mode == 3) ? 19 : 0;
                send_word(pick_func(((k / 90) % 2) == 0), pick_value(), 1'b0, none);
            end
        end

        s_tvalid <= 1'b0;
        stall_pct = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d words in, %0d results checked, deepest fill %0d of %0d",
                 words_in, results_out, max_fill, DEPTH);
        $display("refused pushes %0d, pops on empty %0d, results reporting full %0d",
                 n_refused, n_empty_pop, n_full_seen);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
rtl/dq_pkg.sv
rtl/dq_ctrl.sv
rtl/dq_datapath.sv
rtl/double_ended_queue.sv
sim/tb_top.sv
